// ----- src/sfr_pkg.sv -----
package sfr_pkg;

    localparam int HEADER_BYTES = 2;
    localparam int SAMPLE_COUNT = 256;

    localparam int SPAN_W      = 10;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int INDEX_W     = 10;
    localparam int DEPTH_IDX_W = 16;
    localparam int DEPTH_W     = 24;
    localparam int CM_PER_M    = 100;
    localparam int CM_W        = $clog2(CM_PER_M + 1);
    localparam int SCALE_W     = SPAN_W + CM_W;
    localparam int PROD_W      = DEPTH_IDX_W + SCALE_W;

    localparam int FRAME_LEN_MAX = HEADER_BYTES + 2 * SAMPLE_COUNT;
    localparam int COUNT_W       = $clog2(FRAME_LEN_MAX + 1);

    localparam logic [SPAN_W-1:0]    RESET_SPAN    = SPAN_W'(100);
    localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT = TIMEOUT_W'(100);

    localparam logic [7:0] MARKER_WIDE   = 8'hAA;
    localparam logic [7:0] MARKER_NARROW = 8'hAB;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    localparam logic REG_SPAN    = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } sfr_in_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [INDEX_W-1:0] byte_index;
        logic [7:0]         payload_byte;
        logic               wide_samples;
        logic [DEPTH_W-1:0] depth_cm;
    } sfr_out_t;

endpackage

// ----- src/sonar_frame_receiver.sv -----
// Channel   Direction  Payload                                         Handshake
// s_        in         mode, rx_byte (sfr_in_t)                        s_valid / s_ready
// m_        out        kind, status, byte_index, payload_byte,         m_valid / m_ready
//                      wide_samples, depth_cm (sfr_out_t)
// cfg_      in         cfg_addr selects depth span or timeout_ticks    cfg_we, no wait
//
// One transfer per cycle is accepted while s_ready is high; each input transfer passes
// through the input register, then the result register.
// The depth path is one 16 x 17 multiply followed by a constant shift, both combinational.
// Synchronous active-low reset returns the deframer to marker hunt with reset register values.
// A stalled result holds the input register; s_ready drops only while both registers are full
// and m_ready is low.
module sonar_frame_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sfr_pkg::sfr_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sfr_pkg::sfr_out_t                   m_data,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic                                in_vld_reg, in_vld_next;
    sfr_pkg::sfr_in_t                    in_reg, in_next;
    logic                                m_vld_reg, m_vld_next;
    sfr_pkg::sfr_out_t                   out_reg, out_next;
    logic                                wide_reg, wide_next;
    logic [sfr_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [7:0]                          xor_reg, xor_next;
    logic [sfr_pkg::DEPTH_IDX_W-1:0]     didx_reg, didx_next;
    logic [sfr_pkg::TIMEOUT_W-1:0]       tick_reg, tick_next;
    logic [sfr_pkg::TIMEOUT_W-1:0]       timeout_reg, timeout_next;
    logic [sfr_pkg::SCALE_W-1:0]         scale_reg, scale_next;

    logic                                in_go;
    logic [sfr_pkg::COUNT_W-1:0]         frame_len;
    logic [sfr_pkg::COUNT_W-1:0]         count_inc;
    logic [sfr_pkg::TIMEOUT_W-1:0]       tick_inc;
    logic [sfr_pkg::PROD_W-1:0]          prod;
    logic [sfr_pkg::PROD_W-1:0]          quo;
    logic [sfr_pkg::DEPTH_W-1:0]         depth_sat;

    assign in_go   = in_vld_reg && (!m_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || in_go;
    assign m_valid = m_vld_reg;
    assign m_data  = out_reg;

    assign frame_len = wide_reg
        ? sfr_pkg::COUNT_W'(sfr_pkg::HEADER_BYTES + 2 * sfr_pkg::SAMPLE_COUNT)
        : sfr_pkg::COUNT_W'(sfr_pkg::HEADER_BYTES + sfr_pkg::SAMPLE_COUNT);
    assign count_inc = count_reg + sfr_pkg::COUNT_W'(1);
    assign tick_inc  = (tick_reg == {sfr_pkg::TIMEOUT_W{1'b1}})
                     ? tick_reg : tick_reg + sfr_pkg::TIMEOUT_W'(1);

    assign prod      = sfr_pkg::PROD_W'(didx_reg) * sfr_pkg::PROD_W'(scale_reg);
    assign quo       = prod / sfr_pkg::SAMPLE_COUNT;
    assign depth_sat = (|quo[sfr_pkg::PROD_W-1:sfr_pkg::DEPTH_W])
                     ? {sfr_pkg::DEPTH_W{1'b1}} : quo[sfr_pkg::DEPTH_W-1:0];

    always_comb begin
        phase_next   = phase_reg;
        in_vld_next  = in_vld_reg;
        in_next      = in_reg;
        m_vld_next   = m_vld_reg && !m_ready;
        out_next     = out_reg;
        wide_next    = wide_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        didx_next    = didx_reg;
        tick_next    = tick_reg;
        timeout_next = timeout_reg;
        scale_next   = scale_reg;

        if (cfg_we) begin
            case (cfg_addr)
                sfr_pkg::REG_SPAN: begin
                    scale_next = sfr_pkg::SCALE_W'(cfg_wdata[sfr_pkg::SPAN_W-1:0])
                               * sfr_pkg::SCALE_W'(sfr_pkg::CM_PER_M);
                end
                sfr_pkg::REG_TIMEOUT: begin
                    timeout_next = cfg_wdata[sfr_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
            in_next     = s_data;
        end else if (in_go) begin
            in_vld_next = 1'b0;
        end

        if (in_go) begin
            out_next.kind         = sfr_pkg::KIND_REPORT;
            out_next.status       = sfr_pkg::STATUS_OK;
            out_next.byte_index   = '0;
            out_next.payload_byte = '0;
            out_next.wide_samples = wide_reg;
            out_next.depth_cm     = '0;

            if (in_reg.mode == sfr_pkg::MODE_TICK) begin
                if (phase_reg != PH_HUNT) begin
                    tick_next = tick_inc;
                    if (tick_inc >= timeout_reg) begin
                        out_next.status = sfr_pkg::STATUS_TIMEOUT;
                        m_vld_next      = 1'b1;
                        phase_next      = PH_HUNT;
                    end
                end
            end else begin
                case (phase_reg)
                    PH_PAYLOAD: begin
                        out_next.kind         = sfr_pkg::KIND_PAYLOAD;
                        out_next.byte_index   = sfr_pkg::INDEX_W'(count_reg);
                        out_next.payload_byte = in_reg.rx_byte;
                        m_vld_next            = 1'b1;
                        xor_next              = xor_reg ^ in_reg.rx_byte;
                        if (count_reg == sfr_pkg::COUNT_W'(0)) begin
                            didx_next[7:0] = in_reg.rx_byte;
                        end else if (count_reg == sfr_pkg::COUNT_W'(1)) begin
                            didx_next[15:8] = in_reg.rx_byte;
                        end
                        count_next = count_inc;
                        if (count_inc >= frame_len) begin
                            phase_next = PH_CHECK;
                            tick_next  = '0;
                        end
                    end
                    PH_CHECK: begin
                        if (in_reg.rx_byte == xor_reg) begin
                            out_next.depth_cm = depth_sat;
                        end else begin
                            out_next.status = sfr_pkg::STATUS_BAD_SUM;
                        end
                        m_vld_next = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    default: begin
                        if (in_reg.rx_byte == sfr_pkg::MARKER_WIDE ||
                            in_reg.rx_byte == sfr_pkg::MARKER_NARROW) begin
                            wide_next  = (in_reg.rx_byte == sfr_pkg::MARKER_WIDE);
                            phase_next = PH_PAYLOAD;
                            count_next = '0;
                            xor_next   = '0;
                            didx_next  = '0;
                            tick_next  = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            in_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
            wide_reg    <= 1'b0;
            count_reg   <= '0;
            xor_reg     <= '0;
            didx_reg    <= '0;
            tick_reg    <= '0;
            timeout_reg <= sfr_pkg::RESET_TIMEOUT;
            scale_reg   <= sfr_pkg::SCALE_W'(sfr_pkg::RESET_SPAN)
                         * sfr_pkg::SCALE_W'(sfr_pkg::CM_PER_M);
        end else begin
            phase_reg   <= phase_next;
            in_vld_reg  <= in_vld_next;
            m_vld_reg   <= m_vld_next;
            wide_reg    <= wide_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            didx_reg    <= didx_next;
            tick_reg    <= tick_next;
            timeout_reg <= timeout_next;
            scale_reg   <= scale_next;
        end
        in_reg  <= in_next;
        out_reg <= out_next;
    end

endmodule
